// ===== rtl/ioicr_pkg.sv =====
// ----------------------------------------------------------------------------
// ioicr_pkg
// Shared constants and types for the interrupt controller register window.
// ----------------------------------------------------------------------------
`default_nettype none

package ioicr_pkg;

  localparam int unsigned ENTRIES_DEF = 24;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OFS_W    = 8;
  localparam int unsigned SIZE_W   = 4;

  // Bus offsets
  localparam logic [OFS_W-1:0] OFS_SELECT = 8'h00;
  localparam logic [OFS_W-1:0] OFS_WINDOW = 8'h10;
  localparam logic [OFS_W-1:0] OFS_EOI    = 8'h40;

  // Access kinds and the one size that takes effect
  localparam logic              MODE_READ  = 1'b0;
  localparam logic              MODE_WRITE = 1'b1;
  localparam logic [SIZE_W-1:0] SIZE_WORD  = 4'd4;

  // Select codes
  localparam logic [DATA_W-1:0] SEL_VERSION     = 32'h0000_0001;
  localparam logic [DATA_W-1:0] SEL_FIRST_ENTRY = 32'h0000_0010;
  localparam logic [15:0]       VERSION_ID      = 16'h0011;

  localparam logic [DATA_W-1:0] DATA_ONES = '1;

  // What the first pipeline stage hands to the result stage
  typedef struct packed {
    logic              use_ram;  // result comes from an entry RAM
    logic              upper;    // high word of the entry
    logic              ent_vld;  // entry half written since reset
    logic [DATA_W-1:0] data;     // result when use_ram is low
  } ioicr_s1_t;

endpackage

`default_nettype wire

// ===== rtl/ioicr_req_if.sv =====
// ----------------------------------------------------------------------------
// ioicr_req_if
// Bus access channel: one beat is one read or write access.
// ----------------------------------------------------------------------------
`default_nettype none

interface ioicr_req_if import ioicr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [OFS_W-1:0]  offset;
  logic [SIZE_W-1:0] access_size;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, mode, offset, access_size, write_data, input ready);
  modport sink   (input valid, mode, offset, access_size, write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ioicr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ioicr_rsp_if
// Response channel: one beat per access, carrying the read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ioicr_rsp_if import ioicr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ioicr_ram.sv =====
// ----------------------------------------------------------------------------
// ioicr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ioicr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 24,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/io_interrupt_controller_regs.sv =====
// ----------------------------------------------------------------------------
// io_interrupt_controller_regs
// Index/data register window of an I/O interrupt controller.
//
// Usage: each beat on req is one bus access (mode 0 read, 1 write) with a
// byte offset and a size; only 4-byte accesses take effect, and a read of
// any other size returns all ones. Offset 0x00 is the select register;
// offset 0x10 is the window onto the version word or one half of a
// redirection entry, picked by select. Every access gives exactly one beat
// on rsp; writes answer with zero.
// The response passes the first stage (s1 and the entry RAM read) and then
// the response register.
// Throughput: one access per cycle; the two stages advance together every
// cycle that rsp is ready, and each RAM has its own write and read port.
// Reset clears select and the per-entry written flags, so every entry reads
// zero until written; no clearing pass is needed.
// If rsp stalls, up to two accesses are held inside and req.ready drops
// once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module io_interrupt_controller_regs import ioicr_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  ioicr_req_if.sink req,
  ioicr_rsp_if.source rsp
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [DATA_W-1:0] VERSION_WORD =
    (DATA_W'(ENTRIES - 1) << 16) | DATA_W'(VERSION_ID);

  logic [DATA_W-1:0] select_index;
  logic [ENTRIES-1:0] lo_vld;
  logic [ENTRIES-1:0] hi_vld;

  logic              s1_valid;
  ioicr_s1_t         s1;
  ioicr_s1_t         s1_next;
  logic              o_valid;
  logic [DATA_W-1:0] o_data;

  logic              accept;
  logic              s1_move;
  logic              size_ok;
  logic [DATA_W-1:0] rel;
  logic              hit;
  logic              upper;
  logic [IDX_W-1:0]  idx;
  logic              win_wr;
  logic [DATA_W-1:0] lo_rdata;
  logic [DATA_W-1:0] hi_rdata;
  logic [DATA_W-1:0] s1_result;

  // Select decode: entry i low word at 0x10+2i, high word at 0x11+2i
  assign rel   = select_index - SEL_FIRST_ENTRY;
  assign hit   = (select_index >= SEL_FIRST_ENTRY) &&
                 (rel[DATA_W-1:1] < (DATA_W-1)'(ENTRIES));
  assign upper = rel[0];
  assign idx   = rel[IDX_W:1];

  assign s1_move   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;
  assign size_ok   = (req.access_size == SIZE_WORD);
  assign win_wr    = accept && (req.mode == MODE_WRITE) && size_ok &&
                     (req.offset == OFS_WINDOW) && hit;

  always_comb begin
    s1_next         = '0;
    s1_next.upper   = upper;
    s1_next.ent_vld = upper ? hi_vld[idx] : lo_vld[idx];
    if (req.mode == MODE_WRITE) begin
      s1_next.data = '0;
    end else if (!size_ok) begin
      s1_next.data = DATA_ONES;
    end else begin
      case (req.offset)
        OFS_SELECT: s1_next.data = select_index;
        OFS_WINDOW: begin
          if (select_index == SEL_VERSION) begin
            s1_next.data = VERSION_WORD;
          end else if (hit) begin
            s1_next.use_ram = 1'b1;
          end
        end
        default: s1_next.data = '0;  // EOI and unmapped offsets
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_index <= '0;
      lo_vld       <= '0;
      hi_vld       <= '0;
    end else begin
      if (accept && (req.mode == MODE_WRITE) && size_ok && (req.offset == OFS_SELECT)) begin
        select_index <= req.write_data;
      end
      if (win_wr) begin
        if (upper) begin
          hi_vld[idx] <= 1'b1;
        end else begin
          lo_vld[idx] <= 1'b1;
        end
      end
    end
  end

  ioicr_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_lo_ram (
    .clk     (clk),
    .wr_en   (win_wr && !upper),
    .wr_addr (idx),
    .wr_data (req.write_data),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (lo_rdata)
  );

  ioicr_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_hi_ram (
    .clk     (clk),
    .wr_en   (win_wr && upper),
    .wr_addr (idx),
    .wr_data (req.write_data),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (hi_rdata)
  );

  // RAM read data holds until the next accept, which only happens as s1 moves or while s1 is empty
  always_comb begin
    if (!s1.use_ram) begin
      s1_result = s1.data;
    end else if (!s1.ent_vld) begin
      s1_result = '0;
    end else begin
      s1_result = s1.upper ? hi_rdata : lo_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_move) begin
      o_data <= s1_result;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_data;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !o_valid)
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && o_valid && !rsp.ready |-> !req.ready)
    else $error("request taken while both stages are full");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_WRITE) |=> !s1.use_ram && (s1.data == '0))
    else $error("write beat does not answer zero");

  a_select_read: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_READ) && size_ok && (req.offset == OFS_SELECT)
    |=> s1.data == $past(select_index))
    else $error("select read returned wrong value");

  a_window_wr_hit: assert property (@(posedge clk) disable iff (rst)
    win_wr |=> (upper ? hi_vld[idx] : lo_vld[idx]))
    else $error("entry written flag not set");
`endif

endmodule

`default_nettype wire
